// ----- design/vna_pkg.sv -----
// Shared types and constants of the vertex normal averager.
package vna_pkg;

   localparam int VERTICES = 1024;
   localparam int IDX_W    = $clog2(VERTICES);
   localparam int CNT_W    = 11;
   localparam int POS_W    = 32;
   localparam int NSUM_W   = 24;
   localparam int NRM_W    = 16;
   localparam int MAG_W    = 62;
   localparam int ROOT_W   = 31;
   localparam int QUOT_W   = 15;
   localparam int NUM_W    = 45;

   localparam logic signed [NSUM_W-1:0] NSUM_MAX = 24'sh7FFFFF;
   localparam logic signed [NSUM_W-1:0] NSUM_MIN = 24'sh800000;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_TRI  = 2'd1,
      KIND_READ = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_ZERO  = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_SAT   = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_RD_A, ST_RD_B, ST_RD_C, ST_EDGE, ST_CROSS,
      ST_CR_LOAD, ST_RD_SUM, ST_SCALE, ST_SQUARE, ST_SQRT_GO, ST_SQRT_WAIT,
      ST_DIV_GO, ST_DIV_WAIT, ST_UPD_RD, ST_UPD_WR, ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [IDX_W-1:0]        vertex_index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [NRM_W-1:0] start_nx;
      logic signed [NRM_W-1:0] start_ny;
      logic signed [NRM_W-1:0] start_nz;
      logic [IDX_W-1:0]        corner_a;
      logic [IDX_W-1:0]        corner_b;
      logic [IDX_W-1:0]        corner_c;
   } req_item_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_vertex;
      logic signed [NRM_W-1:0] out_nx;
      logic signed [NRM_W-1:0] out_ny;
      logic signed [NRM_W-1:0] out_nz;
      logic [1:0]              status;
   } rsp_item_type;

   typedef struct packed {
      logic              go;
      logic              is_div;
      logic [MAG_W-1:0]  radicand;
      logic [NUM_W-1:0]  numer;
      logic [ROOT_W-1:0] divisor;
   } sd_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
      logic [QUOT_W-1:0] quot;
   } sd_rsp_type;

endpackage

// ----- design/vna_sqdiv.sv -----
// Bit-serial square root and divider sharing one subtract and compare unit.
module vna_sqdiv
   import vna_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  sd_req_type sd_req,
   output sd_rsp_type sd_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              div_ff, div_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [MAG_W-1:0]  x_ff, x_in;
   logic [MAG_W-1:0]  r_ff, r_in;
   logic [MAG_W-1:0]  bit_ff, bit_in;
   logic [QUOT_W-1:0] numer_lo_ff, numer_lo_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [ROOT_W-1:0] divisor_ff, divisor_in;

   logic [ROOT_W:0]   trial_div;
   logic [MAG_W:0]    op_a, op_b;
   logic [MAG_W+1:0]  diff;
   logic              ge;

   always_comb begin
      trial_div = {x_ff[ROOT_W-1:0], numer_lo_ff[cnt_ff[3:0]]};
      op_a = div_ff ? (MAG_W+1)'(trial_div) : {1'b0, x_ff};
      op_b = div_ff ? (MAG_W+1)'(divisor_ff) : ({1'b0, r_ff} + {1'b0, bit_ff});
      diff = {1'b0, op_a} - {1'b0, op_b};
      ge   = !diff[MAG_W+1];
   end

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      div_in      = div_ff;
      cnt_in      = cnt_ff;
      x_in        = x_ff;
      r_in        = r_ff;
      bit_in      = bit_ff;
      numer_lo_in = numer_lo_ff;
      quot_in     = quot_ff;
      divisor_in  = divisor_ff;
      if (sd_req.go) begin
         busy_in     = 1'b1;
         div_in      = sd_req.is_div;
         divisor_in  = sd_req.divisor;
         numer_lo_in = sd_req.numer[QUOT_W-1:0];
         quot_in     = '0;
         r_in        = '0;
         bit_in      = MAG_W'(1) << 60;
         if (sd_req.is_div) begin
            x_in   = MAG_W'(sd_req.numer[NUM_W-1:QUOT_W]);
            cnt_in = 5'd14;
         end else begin
            x_in   = sd_req.radicand;
            cnt_in = 5'd30;
         end
      end else if (busy_ff) begin
         if (div_ff) begin
            x_in    = ge ? diff[MAG_W-1:0] : MAG_W'(trial_div);
            quot_in = {quot_ff[QUOT_W-2:0], ge};
         end else begin
            x_in   = ge ? diff[MAG_W-1:0] : x_ff;
            r_in   = ge ? ((r_ff >> 1) + bit_ff) : (r_ff >> 1);
            bit_in = bit_ff >> 2;
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      x_ff        <= x_in;
      r_ff        <= r_in;
      bit_ff      <= bit_in;
      numer_lo_ff <= numer_lo_in;
      quot_ff     <= quot_in;
      divisor_ff  <= divisor_in;
   end

   assign sd_rsp.done = done_ff;
   assign sd_rsp.root = r_ff[ROOT_W-1:0];
   assign sd_rsp.quot = quot_ff;

endmodule

// ----- design/vertex_normal_averager.sv -----
// Triangle and read items run the bit-serial square root (31 steps) and the three
// 15-step divisions, all on one shared subtract unit, plus a shared multiplier.
// One item at a time; busy is high from acceptance until the result strobe.
// Synchronous reset clears the sequencer and vertex_count; the vertex
// memories are not cleared and must be loaded before use.
module vertex_normal_averager
   import vna_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [CNT_W-1:0] csr_data
);

   logic signed [POS_W-1:0]  pos_x_mem [VERTICES];
   logic signed [POS_W-1:0]  pos_y_mem [VERTICES];
   logic signed [POS_W-1:0]  pos_z_mem [VERTICES];
   logic signed [NSUM_W-1:0] nsum_x_mem [VERTICES];
   logic signed [NSUM_W-1:0] nsum_y_mem [VERTICES];
   logic signed [NSUM_W-1:0] nsum_z_mem [VERTICES];

   logic signed [POS_W-1:0]  pos_rd_x_ff, pos_rd_y_ff, pos_rd_z_ff;
   logic signed [NSUM_W-1:0] nsum_rd_x_ff, nsum_rd_y_ff, nsum_rd_z_ff;

   state_type               state_ff, state_in;
   req_item_type            req_ff, req_in;
   logic [CNT_W-1:0]        vcount_ff, vcount_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic signed [POS_W-1:0] pa_ff [3];
   logic signed [POS_W-1:0] pa_in [3];
   logic signed [POS_W:0]   e_ff [6];
   logic signed [POS_W:0]   e_in [6];
   logic signed [MAG_W:0]   cr_ff [3];
   logic signed [MAG_W:0]   cr_in [3];
   logic                    sign_ff [3];
   logic                    sign_in [3];
   logic [MAG_W-1:0]        mag_ff [3];
   logic [MAG_W-1:0]        mag_in [3];
   logic [MAG_W-1:0]        len2_ff, len2_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic signed [NRM_W-1:0] n_ff [3];
   logic signed [NRM_W-1:0] n_in [3];
   logic                    sat_ff, sat_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_ff, rsp_in;
   logic signed [63:0]      prod_ff;

   logic signed [31:0]       mul_a, mul_b;
   logic [IDX_W-1:0]         mem_addr;
   logic                     pos_we, nsum_we;
   logic signed [NSUM_W-1:0] nsum_wd [3];
   sd_req_type               sd_req;
   sd_rsp_type               sd_rsp;

   logic [POS_W-1:0]         e_mag [6];
   logic [POS_W-1:0]         e_or;
   logic [1:0]               e_sh;
   logic signed [POS_W:0]    e_shifted [6];
   logic [MAG_W-1:0]         m_or;
   logic [MAG_W-1:0]         sel_mag;
   logic [IDX_W-1:0]         sel_corner;
   logic signed [NSUM_W:0]   upd_sum [3];
   logic                     upd_sat;
   logic signed [NRM_W-1:0]  q_signed;
   logic                     sel_sign;
   logic ok_vi, ok_a, ok_b, ok_c;

   function automatic logic [MAG_W-1:0] abs63(input logic signed [MAG_W:0] v);
      logic [MAG_W:0] t;
      t = v[MAG_W] ? -v : v;
      return t[MAG_W-1:0];
   endfunction

   vna_sqdiv u_sqdiv (
      .clock (clock),
      .reset (reset),
      .sd_req(sd_req),
      .sd_rsp(sd_rsp)
   );

   // Edge magnitudes and the common right shift that keeps them below 2^30.
   always_comb begin
      e_or = '0;
      for (int i = 0; i < 6; i++) begin
         e_mag[i] = e_ff[i][POS_W] ? POS_W'(-e_ff[i]) : POS_W'(e_ff[i]);
         e_or     = e_or | e_mag[i];
      end
      e_sh = e_or[31] ? 2'd2 : (e_or[30] ? 2'd1 : 2'd0);
      for (int i = 0; i < 6; i++) begin
         e_shifted[i] = e_ff[i][POS_W] ? -$signed({1'b0, e_mag[i] >> e_sh})
                                       : $signed({1'b0, e_mag[i] >> e_sh});
      end
   end

   always_comb begin
      m_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      unique case (cnt_ff[1:0])
         2'd0: begin
            sel_mag    = mag_ff[0];
            sel_sign   = sign_ff[0];
            sel_corner = req_ff.corner_a;
         end
         2'd1: begin
            sel_mag    = mag_ff[1];
            sel_sign   = sign_ff[1];
            sel_corner = req_ff.corner_b;
         end
         default: begin
            sel_mag    = mag_ff[2];
            sel_sign   = sign_ff[2];
            sel_corner = req_ff.corner_c;
         end
      endcase
      q_signed = sel_sign ? -$signed({1'b0, sd_rsp.quot}) : $signed({1'b0, sd_rsp.quot});
      upd_sum[0] = NSUM_W'(nsum_rd_x_ff) + (NSUM_W+1)'(n_ff[0]);
      upd_sum[1] = NSUM_W'(nsum_rd_y_ff) + (NSUM_W+1)'(n_ff[1]);
      upd_sum[2] = NSUM_W'(nsum_rd_z_ff) + (NSUM_W+1)'(n_ff[2]);
      upd_sum[0] = $signed({nsum_rd_x_ff[NSUM_W-1], nsum_rd_x_ff})
                 + $signed({{(NSUM_W-NRM_W+1){n_ff[0][NRM_W-1]}}, n_ff[0]});
      upd_sum[1] = $signed({nsum_rd_y_ff[NSUM_W-1], nsum_rd_y_ff})
                 + $signed({{(NSUM_W-NRM_W+1){n_ff[1][NRM_W-1]}}, n_ff[1]});
      upd_sum[2] = $signed({nsum_rd_z_ff[NSUM_W-1], nsum_rd_z_ff})
                 + $signed({{(NSUM_W-NRM_W+1){n_ff[2][NRM_W-1]}}, n_ff[2]});
      upd_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (upd_sum[i][NSUM_W] != upd_sum[i][NSUM_W-1]) begin
            upd_sat    = 1'b1;
            nsum_wd[i] = upd_sum[i][NSUM_W] ? NSUM_MIN : NSUM_MAX;
         end else begin
            nsum_wd[i] = upd_sum[i][NSUM_W-1:0];
         end
      end
      ok_vi = {1'b0, req_ff.vertex_index} < vcount_ff;
      ok_a  = {1'b0, req_ff.corner_a} < vcount_ff;
      ok_b  = {1'b0, req_ff.corner_b} < vcount_ff;
      ok_c  = {1'b0, req_ff.corner_c} < vcount_ff;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      vcount_in    = vcount_ff;
      cnt_in       = cnt_ff;
      pa_in        = pa_ff;
      e_in         = e_ff;
      cr_in        = cr_ff;
      sign_in      = sign_ff;
      mag_in       = mag_ff;
      len2_in      = len2_ff;
      root_in      = root_ff;
      n_in         = n_ff;
      sat_in       = sat_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mul_a        = '0;
      mul_b        = '0;
      mem_addr     = req_ff.vertex_index;
      pos_we       = 1'b0;
      nsum_we      = 1'b0;
      sd_req       = '0;
      sd_req.radicand = len2_ff;
      sd_req.divisor  = root_ff;
      sd_req.numer    = NUM_W'({sel_mag[29:0], 14'b0}) + NUM_W'(root_ff[ROOT_W-1:1]);

      if (csr_valid && csr_ready) begin
         vcount_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            status_in = STAT_OK;
            sat_in    = 1'b0;
            cnt_in    = '0;
            state_in  = ST_RESP;
            if (req_ff.kind == KIND_LOAD) begin
               if (ok_vi) begin
                  pos_we  = 1'b1;
                  nsum_we = 1'b1;
               end else begin
                  status_in = STAT_RANGE;
               end
            end else if (req_ff.kind == KIND_READ) begin
               if (ok_vi) state_in = ST_RD_SUM;
               else status_in = STAT_RANGE;
            end else if (req_ff.kind == KIND_TRI) begin
               if (ok_a && ok_b && ok_c) begin
                  mem_addr = req_ff.corner_a;
                  state_in = ST_RD_A;
               end else begin
                  status_in = STAT_RANGE;
               end
            end else begin
               status_in = STAT_RANGE;
            end
         end
         ST_RD_A: begin
            pa_in[0] = pos_rd_x_ff;
            pa_in[1] = pos_rd_y_ff;
            pa_in[2] = pos_rd_z_ff;
            mem_addr = req_ff.corner_b;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            e_in[0]  = (POS_W+1)'(pos_rd_x_ff) - (POS_W+1)'(pa_ff[0]);
            e_in[1]  = (POS_W+1)'(pos_rd_y_ff) - (POS_W+1)'(pa_ff[1]);
            e_in[2]  = (POS_W+1)'(pos_rd_z_ff) - (POS_W+1)'(pa_ff[2]);
            mem_addr = req_ff.corner_c;
            state_in = ST_RD_C;
         end
         ST_RD_C: begin
            e_in[3]  = (POS_W+1)'(pos_rd_x_ff) - (POS_W+1)'(pa_ff[0]);
            e_in[4]  = (POS_W+1)'(pos_rd_y_ff) - (POS_W+1)'(pa_ff[1]);
            e_in[5]  = (POS_W+1)'(pos_rd_z_ff) - (POS_W+1)'(pa_ff[2]);
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            e_in     = e_shifted;
            cnt_in   = '0;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            // Six products, each accumulated in the cycle after it is formed.
            unique case (cnt_ff)
               3'd0: begin mul_a = e_ff[1][31:0]; mul_b = e_ff[5][31:0]; end
               3'd1: begin mul_a = e_ff[2][31:0]; mul_b = e_ff[4][31:0]; end
               3'd2: begin mul_a = e_ff[2][31:0]; mul_b = e_ff[3][31:0]; end
               3'd3: begin mul_a = e_ff[0][31:0]; mul_b = e_ff[5][31:0]; end
               3'd4: begin mul_a = e_ff[0][31:0]; mul_b = e_ff[4][31:0]; end
               3'd5: begin mul_a = e_ff[1][31:0]; mul_b = e_ff[3][31:0]; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
            unique case (cnt_ff)
               3'd1: cr_in[0] = prod_ff[MAG_W:0];
               3'd2: cr_in[0] = cr_ff[0] - $signed(prod_ff[MAG_W:0]);
               3'd3: cr_in[1] = prod_ff[MAG_W:0];
               3'd4: cr_in[1] = cr_ff[1] - $signed(prod_ff[MAG_W:0]);
               3'd5: cr_in[2] = prod_ff[MAG_W:0];
               3'd6: cr_in[2] = cr_ff[2] - $signed(prod_ff[MAG_W:0]);
               default: ;
            endcase
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) state_in = ST_CR_LOAD;
         end
         ST_CR_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               sign_in[i] = cr_ff[i][MAG_W];
               mag_in[i]  = abs63(cr_ff[i]);
            end
            state_in = ST_SCALE;
         end
         ST_RD_SUM: begin
            sign_in[0] = nsum_rd_x_ff[NSUM_W-1];
            sign_in[1] = nsum_rd_y_ff[NSUM_W-1];
            sign_in[2] = nsum_rd_z_ff[NSUM_W-1];
            mag_in[0]  = abs63((MAG_W+1)'(nsum_rd_x_ff));
            mag_in[1]  = abs63((MAG_W+1)'(nsum_rd_y_ff));
            mag_in[2]  = abs63((MAG_W+1)'(nsum_rd_z_ff));
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            // Bring the largest magnitude into [2^29, 2^30), coarse steps first.
            cnt_in = '0;
            if (m_or == '0) begin
               status_in = STAT_ZERO;
               state_in  = ST_RESP;
            end else if (m_or[MAG_W-1:38] != '0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 8;
            end else if (m_or[37:30] != '0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (m_or[29:21] == '0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 8;
            end else if (!m_or[29]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            mul_a = $signed({2'b00, sel_mag[29:0]});
            mul_b = $signed({2'b00, sel_mag[29:0]});
            if (cnt_ff == 3'd1) len2_in = prod_ff[MAG_W-1:0];
            else if (cnt_ff != 3'd0) len2_in = len2_ff + prod_ff[MAG_W-1:0];
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) state_in = ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            sd_req.go = 1'b1;
            state_in  = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sd_rsp.done) begin
               root_in  = sd_rsp.root;
               cnt_in   = '0;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            sd_req.go     = 1'b1;
            sd_req.is_div = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sd_rsp.done) begin
               unique case (cnt_ff[1:0])
                  2'd0:    n_in[0] = q_signed;
                  2'd1:    n_in[1] = q_signed;
                  default: n_in[2] = q_signed;
               endcase
               if (cnt_ff == 3'd2) begin
                  cnt_in   = '0;
                  state_in = (req_ff.kind == KIND_TRI) ? ST_UPD_RD : ST_RESP;
               end else begin
                  cnt_in   = cnt_ff + 3'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_UPD_RD: begin
            mem_addr = sel_corner;
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            mem_addr = sel_corner;
            nsum_we  = 1'b1;
            sat_in   = sat_ff | upd_sat;
            cnt_in   = cnt_ff + 3'd1;
            if (cnt_ff == 3'd2) begin
               status_in = (sat_ff | upd_sat) ? STAT_SAT : STAT_OK;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_UPD_RD;
            end
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.status = status_ff;
            if (req_ff.kind == KIND_TRI) begin
               rsp_in.out_vertex = req_ff.corner_a;
            end else if (req_ff.kind == KIND_LOAD || req_ff.kind == KIND_READ) begin
               rsp_in.out_vertex = req_ff.vertex_index;
            end
            if (req_ff.kind == KIND_READ && status_ff == STAT_OK) begin
               rsp_in.out_nx = n_ff[0];
               rsp_in.out_ny = n_ff[1];
               rsp_in.out_nz = n_ff[2];
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      cnt_ff    <= cnt_in;
      pa_ff     <= pa_in;
      e_ff      <= e_in;
      cr_ff     <= cr_in;
      sign_ff   <= sign_in;
      mag_ff    <= mag_in;
      len2_ff   <= len2_in;
      root_ff   <= root_in;
      n_ff      <= n_in;
      sat_ff    <= sat_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
      prod_ff   <= mul_a * mul_b;
   end

   // Position memories.
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_x_mem[mem_addr] <= req_ff.pos_x;
         pos_y_mem[mem_addr] <= req_ff.pos_y;
         pos_z_mem[mem_addr] <= req_ff.pos_z;
      end
      pos_rd_x_ff <= pos_x_mem[mem_addr];
      pos_rd_y_ff <= pos_y_mem[mem_addr];
      pos_rd_z_ff <= pos_z_mem[mem_addr];
   end

   // Normal sum memories; a load writes the sign-extended starting normal.
   always_ff @(posedge clock) begin
      if (nsum_we) begin
         if (state_ff == ST_DISPATCH) begin
            nsum_x_mem[mem_addr] <= NSUM_W'(req_ff.start_nx);
            nsum_y_mem[mem_addr] <= NSUM_W'(req_ff.start_ny);
            nsum_z_mem[mem_addr] <= NSUM_W'(req_ff.start_nz);
         end else begin
            nsum_x_mem[mem_addr] <= nsum_wd[0];
            nsum_y_mem[mem_addr] <= nsum_wd[1];
            nsum_z_mem[mem_addr] <= nsum_wd[2];
         end
      end
      nsum_rd_x_ff <= nsum_x_mem[mem_addr];
      nsum_rd_y_ff <= nsum_y_mem[mem_addr];
      nsum_rd_z_ff <= nsum_z_mem[mem_addr];
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- design/vna_checker.sv -----
// Port-level checks of the vertex normal averager and their binding.
module vna_checker
   import vna_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_valid,
   input rsp_item_type rsp_item,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [CNT_W-1:0] csr_data
);

   // An accepted transaction raises busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_done_has_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy fell without a result");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // Only a successful read carries a normal; this check covers results with a status other than OK.
   a_error_zero_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != STAT_OK) |->
         (rsp_item.out_nx == '0 && rsp_item.out_ny == '0 && rsp_item.out_nz == '0))
      else $error("nonzero normal with error status");

endmodule

bind vertex_normal_averager vna_checker u_vna_checker (.*);

// ----- tb/vertex_normal_averager_test.sv -----
// Self-checking testbench for the vertex normal averager: loads, triangles, reads and limits.
module vertex_normal_averager_test;
   timeunit 1ns;
   timeprecision 1ps;
   import vna_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 300;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_item_type     req_item;
   logic             rsp_valid;
   rsp_item_type     rsp_item;
   logic             csr_valid;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data;

   vertex_normal_averager DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Shadow copy of the vertex table and the count register.
   logic [CNT_W-1:0]  shadow_count;
   logic signed [31:0] shadow_px [VERTICES];
   logic signed [31:0] shadow_py [VERTICES];
   logic signed [31:0] shadow_pz [VERTICES];
   int                 shadow_sx [VERTICES];
   int                 shadow_sy [VERTICES];
   int                 shadow_sz [VERTICES];
   bit                 loaded [VERTICES];
   int                 live_idx [$];

   rsp_item_type pending_normals [$];
   int           errors;
   int           idle_pct;
   int           quiet_cycles;
   int           sent_total;
   int           status_seen [4];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic int bit_length(longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
         n++;
         v >>= 1;
      end
      return n;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Scales the vector so its largest component sits near 2^30, then divides by the root.
   function automatic bit unit_vector(input longint v0, v1, v2,
                                      output logic signed [NRM_W-1:0] n0, n1, n2);
      longint          v [3];
      longint unsigned m [3];
      longint unsigned big;
      longint unsigned len2;
      longint unsigned s;
      longint          q;
      int              b;
      logic signed [NRM_W-1:0] n [3];
      v[0] = v0; v[1] = v1; v[2] = v2;
      big = 0;
      len2 = 0;
      n0 = '0; n1 = '0; n2 = '0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(v[i]);
         if (m[i] > big) big = m[i];
      end
      if (big == 0) return 1'b0;
      b = bit_length(big);
      for (int i = 0; i < 3; i++) begin
         if (b > 30) m[i] >>= (b - 30);
         else m[i] <<= (30 - b);
         len2 += m[i] * m[i];
      end
      s = int_sqrt(len2);
      if (s == 0) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         q = longint'((m[i] * 16384 + s / 2) / s);
         n[i] = (v[i] < 0) ? NRM_W'(-q) : NRM_W'(q);
      end
      n0 = n[0]; n1 = n[1]; n2 = n[2];
      return 1'b1;
   endfunction

   function automatic int sat_add(int a, int b, inout bit sat);
      longint t;
      t = longint'(a) + longint'(b);
      if (t > 8388607) begin
         sat = 1'b1;
         return 8388607;
      end
      if (t < -8388608) begin
         sat = 1'b1;
         return -8388608;
      end
      return int'(t);
   endfunction

   function automatic bit index_ok(int i);
      return i < int'(shadow_count);
   endfunction

   function automatic longint shift_trunc(longint v, int k);
      longint m;
      m = longint'(magnitude(v) >> k);
      return (v < 0) ? -m : m;
   endfunction

   // Applies one item to the shadow table and returns the result it must produce.
   function automatic rsp_item_type predict_normal(req_item_type it);
      rsp_item_type r;
      longint e [6];
      longint cr [3];
      longint unsigned big;
      int b;
      int ca, cb, cc, k;
      int corner [3];
      bit sat;
      logic signed [NRM_W-1:0] u0, u1, u2;
      r = '0;
      ca = it.corner_a; cb = it.corner_b; cc = it.corner_c;
      case (it.kind)
         KIND_LOAD: begin
            r.out_vertex = it.vertex_index;
            if (!index_ok(it.vertex_index)) begin
               r.status = STAT_RANGE;
            end else begin
               k = it.vertex_index;
               shadow_px[k] = it.pos_x;
               shadow_py[k] = it.pos_y;
               shadow_pz[k] = it.pos_z;
               shadow_sx[k] = it.start_nx;
               shadow_sy[k] = it.start_ny;
               shadow_sz[k] = it.start_nz;
            end
         end
         KIND_TRI: begin
            r.out_vertex = it.corner_a;
            if (!index_ok(ca) || !index_ok(cb) || !index_ok(cc)) begin
               r.status = STAT_RANGE;
            end else begin
               e[0] = longint'(shadow_px[cb]) - longint'(shadow_px[ca]);
               e[1] = longint'(shadow_py[cb]) - longint'(shadow_py[ca]);
               e[2] = longint'(shadow_pz[cb]) - longint'(shadow_pz[ca]);
               e[3] = longint'(shadow_px[cc]) - longint'(shadow_px[ca]);
               e[4] = longint'(shadow_py[cc]) - longint'(shadow_py[ca]);
               e[5] = longint'(shadow_pz[cc]) - longint'(shadow_pz[ca]);
               big = 0;
               for (int i = 0; i < 6; i++)
                  if (magnitude(e[i]) > big) big = magnitude(e[i]);
               b = bit_length(big);
               if (b > 30)
                  for (int i = 0; i < 6; i++) e[i] = shift_trunc(e[i], b - 30);
               cr[0] = e[1] * e[5] - e[2] * e[4];
               cr[1] = e[2] * e[3] - e[0] * e[5];
               cr[2] = e[0] * e[4] - e[1] * e[3];
               if (!unit_vector(cr[0], cr[1], cr[2], u0, u1, u2)) begin
                  r.status = STAT_ZERO;
               end else begin
                  sat = 1'b0;
                  corner[0] = ca; corner[1] = cb; corner[2] = cc;
                  for (int i = 0; i < 3; i++) begin
                     k = corner[i];
                     shadow_sx[k] = sat_add(shadow_sx[k], u0, sat);
                     shadow_sy[k] = sat_add(shadow_sy[k], u1, sat);
                     shadow_sz[k] = sat_add(shadow_sz[k], u2, sat);
                  end
                  if (sat) r.status = STAT_SAT;
               end
            end
         end
         KIND_READ: begin
            r.out_vertex = it.vertex_index;
            if (!index_ok(it.vertex_index)) begin
               r.status = STAT_RANGE;
            end else begin
               k = it.vertex_index;
               if (!unit_vector(shadow_sx[k], shadow_sy[k], shadow_sz[k], u0, u1, u2)) begin
                  r.status = STAT_ZERO;
               end else begin
                  r.out_nx = u0;
                  r.out_ny = u1;
                  r.out_nz = u2;
               end
            end
         end
         default: r.status = STAT_RANGE;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (pending_normals.size() == 0) begin
            report_mismatch("unexpected result, vertex", rsp_item.out_vertex, -1);
         end else begin
            want = pending_normals.pop_front();
            if (rsp_item.out_vertex !== want.out_vertex)
               report_mismatch("out_vertex", rsp_item.out_vertex, want.out_vertex);
            if (rsp_item.out_nx !== want.out_nx)
               report_mismatch("out_nx", rsp_item.out_nx, want.out_nx);
            if (rsp_item.out_ny !== want.out_ny)
               report_mismatch("out_ny", rsp_item.out_ny, want.out_ny);
            if (rsp_item.out_nz !== want.out_nz)
               report_mismatch("out_nz", rsp_item.out_nz, want.out_nz);
            if (rsp_item.status !== want.status)
               report_mismatch("status", rsp_item.status, want.status);
         end
      end
   end

   // Ends a hung run: counts cycles in which no transaction of any kind is accepted or completes.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("FAIL vertex_normal_averager");
            $finish;
         end
      end
   end

   task automatic send_item(req_item_type it);
      rsp_item_type r;
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      r = predict_normal(it);
      pending_normals.push_back(r);
      status_seen[r.status]++;
      sent_total++;
      if (it.kind == KIND_LOAD && r.status == STAT_OK && !loaded[it.vertex_index]) begin
         loaded[it.vertex_index] = 1'b1;
         live_idx.push_back(it.vertex_index);
      end
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_normals.size() != 0) @(posedge clock);
   endtask

   task automatic write_vertex_count(int value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= CNT_W'(value);
      do @(posedge clock); while (!csr_ready);
      shadow_count = CNT_W'(value);
      csr_valid <= 1'b0;
      @(posedge clock);
      live_idx.delete();
      for (int i = 0; i < VERTICES; i++)
         if (loaded[i] && i < value) live_idx.push_back(i);
   endtask

   function automatic req_item_type noise_item();
      req_item_type it;
      it.kind = 2'($urandom);
      it.vertex_index = IDX_W'($urandom);
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      it.pos_z = $urandom;
      it.start_nx = 16'($urandom);
      it.start_ny = 16'($urandom);
      it.start_nz = 16'($urandom);
      it.corner_a = IDX_W'($urandom);
      it.corner_b = IDX_W'($urandom);
      it.corner_c = IDX_W'($urandom);
      return it;
   endfunction

   task automatic send_load(int idx, int px, int py, int pz, int nx, int ny, int nz);
      req_item_type it;
      it = noise_item();
      it.kind = KIND_LOAD;
      it.vertex_index = IDX_W'(idx);
      it.pos_x = px; it.pos_y = py; it.pos_z = pz;
      it.start_nx = 16'(nx); it.start_ny = 16'(ny); it.start_nz = 16'(nz);
      send_item(it);
   endtask

   task automatic send_tri(int a, int b, int c);
      req_item_type it;
      it = noise_item();
      it.kind = KIND_TRI;
      it.corner_a = IDX_W'(a); it.corner_b = IDX_W'(b); it.corner_c = IDX_W'(c);
      send_item(it);
   endtask

   task automatic send_read(int idx);
      req_item_type it;
      it = noise_item();
      it.kind = KIND_READ;
      it.vertex_index = IDX_W'(idx);
      send_item(it);
   endtask

   function automatic int rand_pos();
      case ($urandom_range(3))
         0: return int'($urandom);
         1: return int'($urandom_range(2000000)) - 1000000;
         2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return int'($urandom_range(1 << 20)) - (1 << 19);
      endcase
   endfunction

   function automatic int rand_start();
      case ($urandom_range(2))
         0: return int'($urandom_range(65535)) - 32768;
         1: return int'($urandom_range(4000)) - 2000;
         default: return $urandom_range(1) ? 32767 : -32768;
      endcase
   endfunction

   task automatic test_directed();
      req_item_type it;
      write_vertex_count(0);
      send_load(0, 1, 2, 3, 4, 5, 6);
      send_read(0);
      write_vertex_count(VERTICES);
      send_load(1023, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32767, -32768, 1);
      send_read(1023);
      write_vertex_count(4);
      send_load(0, 0, 0, 0, 32767, -32768, 0);
      send_load(1, 1 << 16, 0, 0, 0, 0, 0);
      send_load(2, 0, 1 << 16, 0, -32768, 32767, -1);
      send_load(3, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0);
      send_load(4, 7, 7, 7, 7, 7, 7);
      send_tri(0, 1, 2);
      send_tri(0, 0, 0);
      send_tri(1, 2, 3);
      send_tri(0, 1, 4);
      send_tri(1023, 0, 0);
      send_read(0);
      send_read(2);
      send_read(5);
      send_load(3, 5, 5, 5, 0, 0, 0);
      send_read(3);
      it = noise_item();
      it.kind = 2'd3;
      send_item(it);
      // Edges this long collapse to parallel vectors once they are shifted down.
      send_load(0, 32'sh80000000, 0, 0, 0, 0, 0);
      send_load(1, 32'sh7FFFFFFF, 1, 0, 0, 0, 0);
      send_load(2, 32'sh7FFFFFFF, 0, 1, 0, 0, 0);
      send_tri(0, 1, 2);
   endtask

   task automatic test_saturation();
      write_vertex_count(3);
      send_load(0, 0, 0, 0, 0, 0, 32767);
      send_load(1, 1 << 16, 0, 0, 0, 0, 32767);
      send_load(2, 0, 1 << 16, 0, 0, 0, 32767);
      for (int i = 0; i < 515; i++) send_tri(0, 1, 2);
      send_read(0);
      send_tri(0, 2, 1);
      send_read(1);
   endtask

   task automatic test_random(int count, int items, int pct, bit hold_mid);
      req_item_type it;
      int sel;
      idle_pct = pct;
      write_vertex_count(count);
      for (int n = 0; n < items; n++) begin
         if (hold_mid && n == items / 2) wait_drained();
         it = noise_item();
         sel = $urandom_range(99);
         if (live_idx.size() < 3 || sel < 30) begin
            it.kind = KIND_LOAD;
            it.vertex_index = IDX_W'($urandom_range(count - 1));
            it.pos_x = rand_pos(); it.pos_y = rand_pos(); it.pos_z = rand_pos();
            it.start_nx = 16'(rand_start());
            it.start_ny = 16'(rand_start());
            it.start_nz = 16'(rand_start());
         end else if (sel < 65) begin
            it.kind = KIND_TRI;
            it.corner_a = IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
            it.corner_b = IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
            it.corner_c = IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
         end else if (sel < 90) begin
            it.kind = KIND_READ;
            it.vertex_index = IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
         end else if (sel < 95 || count >= VERTICES) begin
            it.kind = 2'd3;
         end else begin
            // Out-of-range index on a real operation; other corners stay in range.
            it.kind = 2'($urandom_range(2));
            it.vertex_index = IDX_W'($urandom_range(VERTICES - 1, count));
            it.corner_a = IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
            it.corner_b = IDX_W'($urandom_range(VERTICES - 1, count));
            it.corner_c = IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
         end
         send_item(it);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      errors = 0;
      idle_pct = 0;
      quiet_cycles = 0;
      sent_total = 0;
      shadow_count = '0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      for (int i = 0; i < VERTICES; i++) loaded[i] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 26;
      test_directed();
      test_saturation();
      test_random($urandom_range(64, 4), 150, 26, 1'b0);
      test_random(VERTICES, 200, 76, 1'b0);
      test_random(VERTICES, 200, 0, 1'b1);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d transactions over several vertex counts: ok %0d, zero %0d,",
               sent_total, status_seen[STAT_OK], status_seen[STAT_ZERO]);
      $display("range %0d, saturated %0d; mismatches %0d.",
               status_seen[STAT_RANGE], status_seen[STAT_SAT], errors);
      if (errors == 0) begin
         $display("PASS vertex_normal_averager");
      end else begin
         $display("FAIL vertex_normal_averager");
      end
      $finish;
   end

endmodule
